### src/tdp_pkg.sv
package tdp_pkg;

	// Width of the number under test; bits of the request above it are ignored.
	localparam int NUMBER_WIDTH = 32;
	// A divisor never needs to pass the square root of the largest number by much.
	localparam int DIV_WIDTH = (NUMBER_WIDTH + 1) / 2 + 1;
	// Room for the running square of the divisor one step past the number.
	localparam int SQ_WIDTH = NUMBER_WIDTH + 2;
	// Counts the bits of the number fed into the serial remainder unit.
	localparam int CNT_WIDTH = $clog2(NUMBER_WIDTH);

	localparam int FIRST_DIVISOR = 3;
	localparam int FIRST_SQUARE = FIRST_DIVISOR * FIRST_DIVISOR;
	localparam int DIVISOR_STEP = 2;
	localparam int ONLY_EVEN_PRIME = 2;

	typedef logic [NUMBER_WIDTH-1:0] num_t;
	typedef logic [DIV_WIDTH-1:0] div_t;
	typedef logic [SQ_WIDTH-1:0] sq_t;
	typedef logic [CNT_WIDTH-1:0] cnt_t;

	typedef struct packed {
		logic done;
		logic zero;
	} rem_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

endpackage

### src/tdp_remainder.sv
// Restoring remainder, one bit of the dividend per cycle, most significant bit first.
module tdp_remainder import tdp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  num_t        dividend,
	input  div_t        divisor,
	output rem_status_t status
);

	logic active_q;
	logic done_q;
	logic zero_q;
	num_t dividend_q;
	div_t divisor_q;
	div_t rem_q;
	cnt_t count_q;

	logic [DIV_WIDTH:0] trial;
	logic [DIV_WIDTH:0] diff;
	div_t next_rem;
	logic last_bit;

	assign trial    = {rem_q, dividend_q[NUMBER_WIDTH-1]};
	assign diff     = trial - {1'b0, divisor_q};
	assign next_rem = diff[DIV_WIDTH] ? trial[DIV_WIDTH-1:0] : diff[DIV_WIDTH-1:0];
	assign last_bit = (count_q == cnt_t'(NUMBER_WIDTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			count_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				count_q  <= '0;
			end else if (active_q) begin
				count_q <= count_q + cnt_t'(1);
				if (last_bit) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dividend_q <= dividend;
			divisor_q  <= divisor;
			rem_q      <= '0;
		end else if (active_q) begin
			dividend_q <= {dividend_q[NUMBER_WIDTH-2:0], 1'b0};
			rem_q      <= next_rem;
			if (last_bit) begin
				zero_q <= (next_rem == '0);
			end
		end
	end

	assign status.done = done_q;
	assign status.zero = zero_q;

endmodule

### src/trial_division_prime_test.sv
// Channel   Direction  Signals                          Contents
// s_axis    request in tvalid, tready, tdata[31:0],     tdata: number; tuser: is_integer
//                      tuser[0]
// m_axis    result out tvalid, tready, tdata[7:0]       tdata: is_prime, bits 7..1 zero
//
// Each request gives exactly one result. A request that is not integer typed, even, or
// equal to one needs no division: it goes from idle straight to the finish state. An odd
// number is divided by 3, 5, 7, ... in a bit-serial remainder unit that takes one bit of
// the number per cycle; a prime near 2^32 needs about 32768 divisors. One request is in
// work at a time; a new one is accepted once the previous result has been placed in the
// output register, even if that result has not yet been taken. Reset is asynchronous
// and leaves the block idle.
module trial_division_prime_test import tdp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] number
	input  logic        s_axis_tuser,   // [0] is_integer
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // [0] is_prime, [7:1] zero
);

	state_t state_q;
	state_t state_next;

	num_t number_q;
	div_t div_q;
	sq_t  sq_q;
	logic result_q;
	logic out_valid_q;
	logic out_prime_q;

	num_t number_in;
	logic trivial_in;
	logic trivial_result;
	logic accept;
	logic past_root;
	logic rem_start;
	logic finish_take;
	rem_status_t rem_status;

	// Only the low NUMBER_WIDTH bits of the request take part in the test.
	assign number_in = num_t'(s_axis_tdata);

	// Items that need no division at all are settled as they arrive.
	assign trivial_in = !s_axis_tuser || !number_in[0] || (number_in == num_t'(1));
	assign trivial_result = s_axis_tuser && (number_in == num_t'(ONLY_EVEN_PRIME));

	// Once the divisor squared passes the number, no factor is left to find.
	assign past_root = (sq_q > sq_t'(number_q));

	assign accept = s_axis_tvalid && s_axis_tready;

	tdp_remainder u_remainder (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (number_q),
		.divisor  (div_q),
		.status   (rem_status)
	);

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_next = trivial_in ? ST_FINISH : ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_next = past_root ? ST_FINISH : ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (rem_status.done) begin
					state_next = rem_status.zero ? ST_FINISH : ST_CHECK;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || m_axis_tready) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		rem_start     = 1'b0;
		finish_take   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			ST_CHECK: begin
				rem_start = !past_root;
			end
			ST_FINISH: begin
				finish_take = !out_valid_q || m_axis_tready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (finish_take) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Divisor and its square advance together: (d + 2)^2 = d^2 + 4d + 4.
	always_ff @(posedge clk) begin
		if (accept) begin
			number_q <= number_in;
			div_q    <= div_t'(FIRST_DIVISOR);
			sq_q     <= sq_t'(FIRST_SQUARE);
			result_q <= trivial_result;
		end else if (state_q == ST_CHECK && past_root) begin
			result_q <= 1'b1;
		end else if (state_q == ST_DIVIDE && rem_status.done) begin
			if (rem_status.zero) begin
				result_q <= 1'b0;
			end else begin
				div_q <= div_q + div_t'(DIVISOR_STEP);
				sq_q  <= sq_q + sq_t'({div_q, 2'b00}) + sq_t'(2 * DIVISOR_STEP);
			end
		end
		if (finish_take) begin
			out_prime_q <= result_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0000000, out_prime_q};

endmodule
